/* design/pnn_pkg.sv */
// ----------------------------------------------------------------------------
// pnn_pkg: shared types and constants for the polygon normal block
// Payload structs, status codes and controller-to-datapath command types.
// ----------------------------------------------------------------------------
package pnn_pkg;

  localparam int unsigned ACC_W = 42;
  localparam int unsigned MAG_W = 30;
  localparam int unsigned SQ_W  = 62;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FEW      = 2'd1;
  localparam logic [1:0] ST_FALLBACK = 2'd2;

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic               last_vertex;
  } pnn_in_t;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [1:0]         status;
  } pnn_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic       take_vertex;  // accumulate input edge, store vertex
    logic       close_edge;   // add closing edge last to first
    logic       load_newell;  // load sums into the scaling unit
    logic       load_cross;   // load fallback cross product
    logic       calc_cross;   // compute fallback cross (multiply stage)
    logic       norm_start;   // start normaliser on the loaded vector
    logic       clear_sums;
    logic       load_out;
    logic [1:0] out_status;
    logic       out_zero;
  } pnn_cmd_t;

  typedef struct packed {
    logic       vec_zero;   // loaded vector is all zero
    logic       norm_done;
  } pnn_stat_t;

endpackage

/* design/pnn_norm.sv */
// ----------------------------------------------------------------------------
// pnn_norm: iterative unit-vector scaler
// Range shift, squared length, bit-serial square root and restoring division.
// ----------------------------------------------------------------------------
module pnn_norm
  import pnn_pkg::*;
#(
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] cx,
  input  logic signed [ACC_W-1:0] cy,
  input  logic signed [ACC_W-1:0] cz,
  output logic                    done,
  output logic signed [15:0]      nx,
  output logic signed [15:0]      ny,
  output logic signed [15:0]      nz
);

  // One spare bit: the scaled magnitude plus half the length can reach 2^44.
  localparam int unsigned NUM_W = MAG_W + OUT_FRAC_BITS + 1;
  localparam int unsigned QCNT_W = $clog2(NUM_W + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SHIFT = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_DIVI  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic [ACC_W-1:0] m_r [3];
  logic [2:0] neg_r;
  logic [1:0] idx_r;
  logic [SQ_W-1:0] sq_r;
  logic [SQ_W+1:0] acc_r;
  logic [63:0] rem_r, res_r, bit_r;
  logic [31:0] len_r;
  logic [NUM_W-1:0] num_r;
  logic [32:0] drem_r;
  logic [NUM_W-1:0] quo_r;
  logic [QCNT_W-1:0] qcnt_r;
  logic [15:0] out_r [3];

  logic [ACC_W-1:0] mx;
  logic [63:0] trial;
  logic [32:0] dsh;
  logic [NUM_W-1:0] qsat;

  always_comb begin
    mx = m_r[0] | m_r[1] | m_r[2];
    trial = res_r + bit_r;
    dsh = {drem_r[31:0], num_r[NUM_W-1]};
    qsat = quo_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_SHIFT;
      S_SHIFT: if (mx[ACC_W-1:MAG_W] == '0) state_nxt = S_SQ;
      S_SQ:    state_nxt = S_SUM;
      S_SUM:   state_nxt = (idx_r == 2'd2) ? S_SQRT : S_SQ;
      S_SQRT:  if (bit_r == 64'd0) state_nxt = S_DIVI;
      S_DIVI:  state_nxt = S_DIV;
      S_DIV:   if (qcnt_r == QCNT_W'(NUM_W)) state_nxt = S_FIN;
      S_FIN:   state_nxt = (idx_r == 2'd2) ? S_IDLE : S_DIVI;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    unique case (state_r)
      S_IDLE: if (start) begin
        m_r[0] <= cx[ACC_W-1] ? ACC_W'(-cx) : cx;
        m_r[1] <= cy[ACC_W-1] ? ACC_W'(-cy) : cy;
        m_r[2] <= cz[ACC_W-1] ? ACC_W'(-cz) : cz;
        neg_r <= {cz[ACC_W-1], cy[ACC_W-1], cx[ACC_W-1]};
        idx_r <= 2'd0;
        acc_r <= '0;
      end
      S_SHIFT: if (mx[ACC_W-1:MAG_W] != '0) begin
        m_r[0] <= m_r[0] >> 1;
        m_r[1] <= m_r[1] >> 1;
        m_r[2] <= m_r[2] >> 1;
      end
      S_SQ: sq_r <= m_r[idx_r][MAG_W-1:0] * m_r[idx_r][MAG_W-1:0];
      S_SUM: begin
        acc_r <= acc_r + (SQ_W+2)'(sq_r);
        idx_r <= (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
        rem_r <= 64'(acc_r + (SQ_W+2)'(sq_r));
        res_r <= '0;
        bit_r <= 64'd1 << 62;
      end
      S_SQRT: if (bit_r != 64'd0) begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end else begin
        len_r <= res_r[31:0];
      end
      S_DIVI: begin
        num_r <= NUM_W'({m_r[idx_r][MAG_W-1:0], {OUT_FRAC_BITS{1'b0}}}
                 + NUM_W'(len_r >> 1));
        drem_r <= '0;
        quo_r <= '0;
        qcnt_r <= '0;
      end
      S_DIV: if (qcnt_r != QCNT_W'(NUM_W)) begin
        num_r <= num_r << 1;
        qcnt_r <= qcnt_r + 1'b1;
        if (dsh >= {1'b0, len_r}) begin
          drem_r <= dsh - {1'b0, len_r};
          quo_r <= {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          drem_r <= dsh;
          quo_r <= {quo_r[NUM_W-2:0], 1'b0};
        end
      end
      S_FIN: begin
        out_r[idx_r] <= neg_r[idx_r]
          ? 16'(-((qsat > NUM_W'(32767)) ? 17'd32767 : 17'(qsat)))
          : ((qsat > NUM_W'(32767)) ? 16'd32767 : 16'(qsat));
        idx_r <= idx_r + 2'd1;
      end
      default: ;
    endcase
  end

  assign done = (state_r == S_FIN) && (idx_r == 2'd2);
  assign nx = (idx_r == 2'd2 && state_r == S_FIN && 1'b0) ? 16'sd0 : out_r[0];
  assign ny = out_r[1];
  assign nz = (done) ? (neg_r[2]
          ? 16'(-((qsat > NUM_W'(32767)) ? 17'd32767 : 17'(qsat)))
          : ((qsat > NUM_W'(32767)) ? 16'd32767 : 16'(qsat))) : out_r[2];

endmodule

/* design/pnn_datapath.sv */
// ----------------------------------------------------------------------------
// pnn_datapath: Newell accumulators, vertex stores and fallback cross product
// Executes controller commands; the normaliser is instanced here.
// ----------------------------------------------------------------------------
module pnn_datapath
  import pnn_pkg::*;
#(
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  input  pnn_in_t   in_item,
  input  pnn_cmd_t  cmd,
  input  logic [1:0] head_idx,
  input  logic      has_prev,
  output pnn_stat_t stat,
  output pnn_out_t  out_item
);

  logic signed [15:0] hx_r [3], hy_r [3], hz_r [3];
  logic signed [15:0] px_r, py_r, pz_r;
  logic signed [ACC_W-1:0] sx_r, sy_r, sz_r;
  logic signed [ACC_W-1:0] cx_r, cy_r, cz_r;
  logic signed [16:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [33:0] p_r [6];
  logic signed [15:0] ax, ay, az, bx, by, bz;
  logic signed [16:0] dy, dz, dx, tz, tx, ty;
  logic signed [33:0] t0, t1, t2;
  logic n_done;
  logic signed [15:0] nx, ny, nz;

  always_comb begin
    if (cmd.close_edge) begin
      ax = px_r; ay = py_r; az = pz_r; bx = hx_r[0]; by = hy_r[0]; bz = hz_r[0];
    end else begin
      ax = px_r; ay = py_r; az = pz_r; bx = in_item.vx; by = in_item.vy; bz = in_item.vz;
    end
    dy = 17'(ay) - 17'(by); tz = 17'(az) + 17'(bz);
    dz = 17'(az) - 17'(bz); tx = 17'(ax) + 17'(bx);
    dx = 17'(ax) - 17'(bx); ty = 17'(ay) + 17'(by);
    t0 = dy * tz; t1 = dz * tx; t2 = dx * ty;
    e1x = 17'(hx_r[0]) - 17'(hx_r[1]); e2x = 17'(hx_r[0]) - 17'(hx_r[2]);
    e1y = 17'(hy_r[0]) - 17'(hy_r[1]); e2y = 17'(hy_r[0]) - 17'(hy_r[2]);
    e1z = 17'(hz_r[0]) - 17'(hz_r[1]); e2z = 17'(hz_r[0]) - 17'(hz_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0; sy_r <= '0; sz_r <= '0;
    end else if (cmd.clear_sums) begin
      sx_r <= '0; sy_r <= '0; sz_r <= '0;
    end else if ((cmd.take_vertex && has_prev) || cmd.close_edge) begin
      sx_r <= sx_r + ACC_W'(t0);
      sy_r <= sy_r + ACC_W'(t1);
      sz_r <= sz_r + ACC_W'(t2);
    end
    if (cmd.take_vertex) begin
      px_r <= in_item.vx; py_r <= in_item.vy; pz_r <= in_item.vz;
      if (head_idx != 2'd3) begin
        hx_r[head_idx] <= in_item.vx;
        hy_r[head_idx] <= in_item.vy;
        hz_r[head_idx] <= in_item.vz;
      end
    end
    if (cmd.calc_cross) begin
      p_r[0] <= e1y * e2z; p_r[1] <= e1z * e2y;
      p_r[2] <= e1z * e2x; p_r[3] <= e1x * e2z;
      p_r[4] <= e1x * e2y; p_r[5] <= e1y * e2x;
    end
    if (cmd.load_newell) begin
      cx_r <= sx_r; cy_r <= sy_r; cz_r <= sz_r;
    end else if (cmd.load_cross) begin
      cx_r <= ACC_W'(p_r[0]) - ACC_W'(p_r[1]);
      cy_r <= ACC_W'(p_r[2]) - ACC_W'(p_r[3]);
      cz_r <= ACC_W'(p_r[4]) - ACC_W'(p_r[5]);
    end
    if (cmd.load_out) begin
      out_item.status <= cmd.out_status;
      out_item.nx <= cmd.out_zero ? 16'sd0 : nx;
      out_item.ny <= cmd.out_zero ? 16'sd0 : ny;
      out_item.nz <= cmd.out_zero ? 16'sd0 : nz;
    end
  end

  pnn_norm #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_norm (
    .clk(clk), .rst_n(rst_n), .start(cmd.norm_start),
    .cx(cx_r), .cy(cy_r), .cz(cz_r),
    .done(n_done), .nx(nx), .ny(ny), .nz(nz)
  );

  assign stat.vec_zero  = (cx_r == '0) && (cy_r == '0) && (cz_r == '0);
  assign stat.norm_done = n_done;

endmodule

/* design/pnn_ctrl.sv */
// ----------------------------------------------------------------------------
// pnn_ctrl: sequencer for the polygon normal block
// Counts vertices, runs closing edge, normalisation, fallback and output.
// ----------------------------------------------------------------------------
module pnn_ctrl
  import pnn_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  input  pnn_stat_t  stat,
  output pnn_cmd_t   cmd,
  output logic [1:0] head_idx,
  output logic       has_prev
);

  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);

  localparam logic [2:0] S_ACC   = 3'd0;
  localparam logic [2:0] S_CLOSE = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_NORM  = 3'd3;
  localparam logic [2:0] S_XLOAD = 3'd4;
  localparam logic [2:0] S_XSTRT = 3'd5;
  localparam logic [2:0] S_NWAIT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic fb_r, fb_nxt;
  logic ov_r;
  logic take;
  logic [CNT_W-1:0] cnt_inc;

  assign in_ready = (state_r == S_ACC) && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign take = in_valid && in_ready;
  assign cnt_inc = (cnt_r < CNT_W'(MAX_VERTICES)) ? cnt_r + 1'b1 : cnt_r;
  assign head_idx = (cnt_r < CNT_W'(3)) ? cnt_r[1:0] : 2'd3;
  assign has_prev = (cnt_r != '0);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    fb_nxt = fb_r;
    unique case (state_r)
      S_ACC: if (take) begin
        cmd.take_vertex = 1'b1;
        if (in_last) begin
          if (cnt_inc < CNT_W'(3)) begin
            cmd.load_out = 1'b1;
            cmd.out_zero = 1'b1;
            cmd.out_status = ST_FEW;
            cmd.clear_sums = 1'b1;
          end else begin
            state_nxt = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        cmd.close_edge = 1'b1;
        cmd.calc_cross = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_newell = 1'b1;
        fb_nxt = 1'b0;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (stat.vec_zero) begin
          if (fb_r) begin
            cmd.load_out = 1'b1; cmd.out_zero = 1'b1;
            cmd.out_status = ST_FALLBACK; cmd.clear_sums = 1'b1;
            state_nxt = S_ACC;
          end else begin
            state_nxt = S_XLOAD;
          end
        end else begin
          cmd.norm_start = 1'b1;
          state_nxt = S_NWAIT;
        end
      end
      S_XLOAD: begin
        cmd.load_cross = 1'b1;
        fb_nxt = 1'b1;
        state_nxt = S_NORM;
      end
      S_NWAIT: if (stat.norm_done) begin
        cmd.load_out = 1'b1;
        cmd.out_status = fb_r ? ST_FALLBACK : ST_OK;
        cmd.clear_sums = 1'b1;
        state_nxt = S_ACC;
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      cnt_r <= '0;
      fb_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fb_r <= fb_nxt;
      if (cmd.clear_sums) cnt_r <= '0;
      else if (cmd.take_vertex) cnt_r <= cnt_inc;
      if (cmd.load_out) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

endmodule

/* design/polygon_normal_newell.sv */
// ----------------------------------------------------------------------------
// polygon_normal_newell: unit polygon normal by Newell's method
// The last vertex runs the closing edge, a range shift, a 32-step square root and
// three 45-step divisions; the fallback path adds S_XLOAD and a second S_NORM pass,
// and no normalisation runs if both vectors are zero. Throughput: one vertex per
// cycle in a polygon unless a result awaits out_ready; input waits at polygon ends.
// A polygon of fewer than three vertices gives its result in the cycle after transfer.
// Reset (rst_n, synchronous, low) clears the sums, the vertex count and all control.
// ----------------------------------------------------------------------------
module polygon_normal_newell
  import pnn_pkg::*;
#(
  parameter int unsigned MAX_VERTICES  = 256,
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pnn_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pnn_out_t out_data
);

  // The controller issues commands; the datapath holds all arithmetic.
  pnn_cmd_t   cmd;
  pnn_stat_t  stat;
  logic [1:0] head_idx;
  logic       has_prev;

  pnn_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_last(in_data.last_vertex),
    .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd), .head_idx(head_idx), .has_prev(has_prev)
  );

  pnn_datapath #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_data), .cmd(cmd),
    .head_idx(head_idx), .has_prev(has_prev), .stat(stat), .out_item(out_data)
  );

endmodule
